// File: rtl/updc_pkg.sv
// Shared types and constants for the URL path decode and check block.
package updc_pkg;

   localparam int unsigned LINE_BYTES  = 8192;
   localparam int unsigned LIMIT_W     = 13;
   localparam int unsigned COUNT_W     = 14;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(LINE_BYTES - 1);
   localparam logic [LIMIT_W-1:0] MAX_LEN_RESET = LIMIT_W'(8191);

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_QMARK   = 8'h3F;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_TOO_LONG = 3'd1,
      RSN_BAD_ESC  = 3'd2,
      RSN_NUL      = 3'd3,
      RSN_NOT_ABS  = 3'd4,
      RSN_PARENT   = 3'd5,
      RSN_BSLASH   = 3'd6
   } reason_type;

   // One classified event passed from the front end to the checker.
   typedef struct packed {
      logic       esc_err;   // bad or cut-off escape seen on this byte
      logic       have;      // a decoded byte completed
      logic [7:0] dec;       // the decoded byte
      logic       last;      // end of URI
      logic       too_long;  // raw path count over limit (valid with last)
   } entry_type;

endpackage

// File: rtl/updc_front.sv
// Front end: takes raw URI bytes, strips the query, percent-decodes and counts.
module updc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_byte,
   input  logic                          req_last,
   input  logic                          req_fire,
   input  logic [updc_pkg::LIMIT_W-1:0]  max_len,
   output logic                          push,
   output updc_pkg::entry_type           push_entry
);
   import updc_pkg::*;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_type;

   esc_type              phase_ff,  phase_in;
   logic [3:0]           nib_ff,    nib_in;
   logic                 query_ff,  query_in;
   logic [COUNT_W-1:0]   count_ff,  count_in;
   logic [LIMIT_W-1:0]   limit;
   logic [4:0]           hex;
   entry_type            ev;

   // bit 4 set means not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) r = 5'(b - 8'h30);
      else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h57);
      else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h37);
      return r;
   endfunction

   assign limit = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
   assign hex   = hex_digit(req_byte);

   always_comb begin
      phase_in = phase_ff;
      nib_in   = nib_ff;
      query_in = query_ff;
      count_in = count_ff;
      ev       = '0;
      ev.last  = req_last;
      if (!query_ff) begin
         if (req_byte == CH_QMARK) begin
            if (phase_ff != ESC_IDLE) ev.esc_err = 1'b1;
            phase_in = ESC_IDLE;
            query_in = 1'b1;
         end else begin
            if (count_ff < COUNT_MAX) count_in = count_ff + 1'b1;
            unique case (phase_ff)
               ESC_IDLE: begin
                  if (req_byte == CH_PERCENT) begin
                     phase_in = ESC_HIGH;
                  end else begin
                     ev.have = 1'b1;
                     ev.dec  = (req_byte == CH_PLUS) ? CH_SPACE : req_byte;
                  end
               end
               ESC_HIGH: begin
                  if (hex[4]) begin
                     ev.esc_err = 1'b1;
                     phase_in   = ESC_IDLE;
                  end else begin
                     nib_in   = hex[3:0];
                     phase_in = ESC_LOW;
                  end
               end
               ESC_LOW: begin
                  phase_in = ESC_IDLE;
                  if (hex[4]) begin
                     ev.esc_err = 1'b1;
                  end else begin
                     ev.have = 1'b1;
                     ev.dec  = {nib_ff, hex[3:0]};
                  end
               end
               default: phase_in = ESC_IDLE;
            endcase
         end
      end
      // escape left open at end of URI
      if (req_last && phase_in != ESC_IDLE) ev.esc_err = 1'b1;
      ev.too_long = req_last && (count_in > {1'b0, limit});
   end

   assign push       = req_fire && (ev.have || ev.esc_err || ev.last);
   assign push_entry = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_IDLE;
         nib_ff   <= '0;
         query_ff <= 1'b0;
         count_ff <= '0;
      end else if (req_fire) begin
         if (req_last) begin
            phase_ff <= ESC_IDLE;
            nib_ff   <= '0;
            query_ff <= 1'b0;
            count_ff <= '0;
         end else begin
            phase_ff <= phase_in;
            nib_ff   <= nib_in;
            query_ff <= query_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// File: rtl/updc_fifo.sv
// Two-entry queue between the front end and the checker.
module updc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  updc_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output updc_pkg::entry_type  head
);
   import updc_pkg::*;

   entry_type   mem_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// File: rtl/updc_back.sv
// Checker: tracks segments and errors over decoded bytes, drives the result register.
module updc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ent_valid,
   input  updc_pkg::entry_type  ent,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_valid,
   output logic                 rsp_out_last,
   output logic                 rsp_accepted,
   output logic [2:0]           rsp_reject_reason,
   output logic                 rsp_root_only
);
   import updc_pkg::*;

   logic [1:0]  dcnt_ff,   dcnt_in;
   logic        first_ff,  first_in;
   logic [1:0]  seg_ff,    seg_in;
   logic        bad_ff,    bad_in;
   logic        nul_ff,    nul_in;
   logic        par_ff,    par_in;
   logic        bsl_ff,    bsl_in;
   reason_type  reason;

   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        ovalid_ff, olast_ff, acc_ff, root_ff;
   reason_type  reason_ff;

   assign pop = ent_valid && (!valid_ff || rsp_ready);

   always_comb begin
      dcnt_in  = dcnt_ff;
      first_in = first_ff;
      seg_in   = seg_ff;
      bad_in   = bad_ff;
      nul_in   = nul_ff;
      par_in   = par_ff;
      bsl_in   = bsl_ff;
      reason   = RSN_NONE;
      if (ent.esc_err && !(bad_ff || nul_ff)) bad_in = 1'b1;
      if (ent.have) begin
         if (ent.dec == CH_NUL && !(bad_ff || nul_ff)) nul_in = 1'b1;
         if (dcnt_ff == 2'd0) first_in = (ent.dec == CH_SLASH);
         if (dcnt_ff != 2'd3) dcnt_in = dcnt_ff + 2'd1;
         if (ent.dec == CH_BSLASH) bsl_in = 1'b1;
         if (ent.dec == CH_SLASH || ent.dec == CH_BSLASH) begin
            if (seg_ff == 2'd2) par_in = 1'b1;
            seg_in = 2'd0;
         end else if (ent.dec == CH_DOT) begin
            if (seg_ff != 2'd3) seg_in = seg_ff + 2'd1;
         end else begin
            seg_in = 2'd3;
         end
      end
      if (ent.last && seg_in == 2'd2) par_in = 1'b1;
      if (ent.too_long)                         reason = RSN_TOO_LONG;
      else if (bad_in)                          reason = RSN_BAD_ESC;
      else if (nul_in)                          reason = RSN_NUL;
      else if (dcnt_in == 2'd0 || !first_in)    reason = RSN_NOT_ABS;
      else if (par_in)                          reason = RSN_PARENT;
      else if (bsl_in)                          reason = RSN_BSLASH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff  <= '0;
         first_ff <= 1'b0;
         seg_ff   <= '0;
         bad_ff   <= 1'b0;
         nul_ff   <= 1'b0;
         par_ff   <= 1'b0;
         bsl_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            // an entry that only carries an escape error updates state, no result
            valid_ff <= ent.have || ent.last;
            if (ent.last) begin
               dcnt_ff  <= '0;
               first_ff <= 1'b0;
               seg_ff   <= '0;
               bad_ff   <= 1'b0;
               nul_ff   <= 1'b0;
               par_ff   <= 1'b0;
               bsl_ff   <= 1'b0;
            end else begin
               dcnt_ff  <= dcnt_in;
               first_ff <= first_in;
               seg_ff   <= seg_in;
               bad_ff   <= bad_in;
               nul_ff   <= nul_in;
               par_ff   <= par_in;
               bsl_ff   <= bsl_in;
            end
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff   <= ent.have ? ent.dec : 8'h00;
         ovalid_ff <= ent.have;
         olast_ff  <= ent.last;
         acc_ff    <= ent.last && (reason == RSN_NONE);
         reason_ff <= ent.last ? reason : RSN_NONE;
         root_ff   <= ent.last && (reason == RSN_NONE) && (dcnt_in == 2'd1) && first_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_out_valid     = ovalid_ff;
   assign rsp_out_last      = olast_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_reject_reason = reason_ff;
   assign rsp_root_only     = root_ff;

endmodule

// File: rtl/url_path_decode_check.sv
// Top level: streaming URL path percent-decoder and path safety checker.
// Path: a resulting byte passes the queue, then the result register, before rsp.
// Throughput: one byte per cycle sustained; the front end stalls only when the
//   two-entry queue is full, which happens only while the result port is stalled.
// Reset: synchronous, active high; clears all per-URI state and sets
//   max_path_len to 8191. No clearing pass is needed.
module url_path_decode_check (
   input  logic         clock,
   input  logic         reset,
   // input transactions: one raw URI byte each
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_in_last,
   // result transactions: decoded byte and/or verdict
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_out_valid,
   output logic         rsp_out_last,
   output logic         rsp_accepted,
   output logic [2:0]   rsp_reject_reason,
   output logic         rsp_root_only,
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import updc_pkg::*;

   logic [LIMIT_W-1:0]  max_len_ff;
   logic                req_fire;
   logic                push, q_full, q_valid, pop;
   entry_type           push_entry, head;
   logic                reg0_sel;

   // Register 0 (max_path_len) at byte address 0; address bit 2 picks the word.
   assign reg0_sel   = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = reg0_sel ? {{(32-LIMIT_W){1'b0}}, max_len_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && reg0_sel) begin
         max_len_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   // Input is taken whenever the queue has room; bytes that produce no
   // event (percent sign and first hex digit of an escape, query bytes) are consumed without a queue entry.
   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   updc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_byte   (req_in_byte),
      .req_last   (req_in_last),
      .req_fire   (req_fire),
      .max_len    (max_len_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decouples classification from checking so each side stalls on its own.
   updc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .not_empty  (q_valid),
      .head       (head)
   );

   // Checker pops an entry whenever the result register is free or draining.
   updc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .ent_valid         (q_valid),
      .ent               (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_last      (rsp_out_last),
      .rsp_accepted      (rsp_accepted),
      .rsp_reject_reason (rsp_reject_reason),
      .rsp_root_only     (rsp_root_only)
   );

endmodule

// File: tb/testbench.sv
// Testbench for url_path_decode_check: directed and random URIs checked against a path predictor.
`timescale 1ns / 1ps

module testbench;
   import updc_pkg::*;

   // Register map: max_path_len sits at byte address 0.
   localparam logic [2:0] ADDR_MAX_PATH_LEN = 3'd0;

   // Cycles to wait once the result queue drains. Escape and query bytes give
   // no transaction, so the block may still be busy with them at that point.
   localparam int DRAIN_CYCLES = 8;

   // Predictor escape phases and segment states.
   localparam logic [1:0] ESC_IDLE   = 2'd0;
   localparam logic [1:0] ESC_HIGH   = 2'd1;
   localparam logic [1:0] ESC_LOW    = 2'd2;
   localparam logic [1:0] SEG_START  = 2'd0;
   localparam logic [1:0] SEG_DOT    = 2'd1;
   localparam logic [1:0] SEG_DOTDOT = 2'd2;
   localparam logic [1:0] SEG_OTHER  = 2'd3;

   localparam logic [7:0] CH_DIGIT0  = "0";
   localparam logic [7:0] CH_DIGIT9  = "9";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_F = "f";
   localparam logic [7:0] CH_LOWER_G = "g";
   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_F = "F";

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_in_last;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_out_last;
   logic        rsp_accepted;
   logic [2:0]  rsp_reject_reason;
   logic        rsp_root_only;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   url_path_decode_check u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_in_last       (req_in_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_out_last      (rsp_out_last),
      .rsp_accepted      (rsp_accepted),
      .rsp_reject_reason (rsp_reject_reason),
      .rsp_root_only     (rsp_root_only),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // One result transaction as the block should present it.
   typedef struct {
      logic [7:0] data;
      bit         data_valid;
      bit         last;
      bit         accepted;
      reason_type reason;
      bit         root;
   } path_result_type;

   // Directed row: a URI, an optional raw byte poked in (to get NUL and 0xFF
   // into the stream), an optional new limit written before it, and a verdict
   // typed in where it is obvious.
   typedef struct {
      string      uri;
      int         poke_at;
      logic [7:0] poke_val;
      int         new_limit;
      bit         typed;
      reason_type reason;
      bit         root;
   } dir_row_type;

   path_result_type pending_results[$];
   logic [7:0]      uri_bytes[$];
   dir_row_type     dir_table[$];
   int              mismatch_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;

   // Predictor state: a private copy of the limit and the per-URI scan state.
   logic [12:0] len_limit;
   bit          in_query;
   logic [1:0]  esc_phase;
   logic [3:0]  esc_hi;
   logic [13:0] raw_count;
   logic [1:0]  dec_count;
   bit          lead_slash;
   logic [1:0]  seg_state;
   bit          err_esc, err_nul, err_parent, err_bslash;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run at the heaviest idling.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function void clear_path_state();
      in_query   = 1'b0;
      esc_phase  = ESC_IDLE;
      esc_hi     = 4'd0;
      raw_count  = '0;
      dec_count  = 2'd0;
      lead_slash = 1'b0;
      seg_state  = SEG_START;
      err_esc    = 1'b0;
      err_nul    = 1'b0;
      err_parent = 1'b0;
      err_bslash = 1'b0;
   endfunction

   // Only the first escape-class error (bad escape or NUL) is remembered.
   function void flag_escape_error(input bit is_nul);
      if (!err_esc && !err_nul) begin
         if (is_nul) err_nul = 1'b1;
         else err_esc = 1'b1;
      end
   endfunction

   // Advance the path scan by one raw byte; queue the result it causes, if any.
   function void decode_path_byte(input logic [7:0] b, input bit last);
      logic [7:0]      d;
      bit              have;
      logic [4:0]      nib;
      logic [12:0]     cap;
      path_result_type r;
      reason_type      why;
      d    = 8'd0;
      have = 1'b0;
      if (!in_query) begin
         if (b == CH_QMARK) begin
            // query part starts; an open escape is cut off
            if (esc_phase != ESC_IDLE) begin
               flag_escape_error(1'b0);
               esc_phase = ESC_IDLE;
            end
            in_query = 1'b1;
         end else begin
            if (raw_count != COUNT_MAX) raw_count++;
            if (esc_phase == ESC_IDLE) begin
               if (b == CH_PERCENT) esc_phase = ESC_HIGH;
               else begin
                  d    = (b == CH_PLUS) ? CH_SPACE : b;
                  have = 1'b1;
               end
            end else begin
               if (b >= CH_DIGIT0 && b <= CH_DIGIT9) nib = 5'(b - CH_DIGIT0);
               else if (b >= CH_LOWER_A && b <= CH_LOWER_F) nib = 5'(b - CH_LOWER_A + 8'd10);
               else if (b >= CH_UPPER_A && b <= CH_UPPER_F) nib = 5'(b - CH_UPPER_A + 8'd10);
               else nib = 5'd16;
               if (nib[4]) begin
                  // non-hex digit: escape dropped, byte swallowed
                  flag_escape_error(1'b0);
                  esc_phase = ESC_IDLE;
               end else if (esc_phase == ESC_HIGH) begin
                  esc_hi    = nib[3:0];
                  esc_phase = ESC_LOW;
               end else begin
                  d         = {esc_hi, nib[3:0]};
                  have      = 1'b1;
                  esc_phase = ESC_IDLE;
               end
            end
         end
      end

      if (have) begin
         if (d == CH_NUL) flag_escape_error(1'b1);
         if (dec_count == 2'd0) lead_slash = (d == CH_SLASH);
         if (dec_count != 2'd3) dec_count++;
         if (d == CH_BSLASH) err_bslash = 1'b1;
         // both slash kinds end a segment for the parent check
         if (d == CH_SLASH || d == CH_BSLASH) begin
            if (seg_state == SEG_DOTDOT) err_parent = 1'b1;
            seg_state = SEG_START;
         end else if (d == CH_DOT) begin
            if (seg_state != SEG_OTHER) seg_state++;
         end else seg_state = SEG_OTHER;
      end

      if (!have && !last) return;

      r.data       = have ? d : 8'd0;
      r.data_valid = have;
      r.last       = last;
      r.accepted   = 1'b0;
      r.reason     = RSN_NONE;
      r.root       = 1'b0;
      if (last) begin
         cap = (len_limit > LIMIT_CAP) ? LIMIT_CAP : len_limit;
         if (esc_phase != ESC_IDLE) flag_escape_error(1'b0);
         if (seg_state == SEG_DOTDOT) err_parent = 1'b1;
         if (raw_count > {1'b0, cap}) why = RSN_TOO_LONG;
         else if (err_esc) why = RSN_BAD_ESC;
         else if (err_nul) why = RSN_NUL;
         else if (dec_count == 2'd0 || !lead_slash) why = RSN_NOT_ABS;
         else if (err_parent) why = RSN_PARENT;
         else if (err_bslash) why = RSN_BSLASH;
         else why = RSN_NONE;
         r.reason   = why;
         r.accepted = (why == RSN_NONE);
         r.root     = (why == RSN_NONE) && dec_count == 2'd1 && lead_slash;
         clear_path_state();
      end
      pending_results.push_back(r);
   endfunction

   // Hex digit character, case picked at random.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_DIGIT0 + 8'(n);
      return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(n) - 8'd10;
   endfunction

   function void push_escape(input logic [7:0] v);
      uri_bytes.push_back(CH_PERCENT);
      uri_bytes.push_back(hex_char(v[7:4]));
      uri_bytes.push_back(hex_char(v[3:0]));
   endfunction

   // Random URI: mostly well-formed paths with random content, plus broken
   // escapes, boundary-length paths and raw noise.
   function void make_random_uri();
      int unsigned kind;
      int unsigned segs;
      int unsigned piece;
      int unsigned sep;
      uri_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 12)) uri_bytes.push_back(8'($urandom_range(255)));
      end else if (kind < 16 && len_limit <= 13'd64) begin
         // straddle the length limit: exactly at, one over, two over
         uri_bytes.push_back(CH_SLASH);
         repeat (int'(len_limit) - 1 + $urandom_range(2))
            uri_bytes.push_back(CH_LOWER_A + 8'($urandom_range(25)));
      end else begin
         if ($urandom_range(9) != 0) uri_bytes.push_back(CH_SLASH);
         else uri_bytes.push_back(CH_LOWER_A + 8'($urandom_range(25)));
         segs = $urandom_range(4);
         for (int s = 0; s < segs; s++) begin
            piece = $urandom_range(9);
            case (piece)
               0: uri_bytes.push_back(CH_DOT);
               1: begin
                  uri_bytes.push_back(CH_DOT);
                  uri_bytes.push_back(CH_DOT);
               end
               2: repeat (3) uri_bytes.push_back(CH_DOT);
               3: begin
                  // encoded parent
                  push_escape(CH_DOT);
                  uri_bytes.push_back(CH_DOT);
               end
               4: push_escape(8'($urandom_range(255)));
               5: uri_bytes.push_back(CH_PLUS);
               default: begin
                  repeat ($urandom_range(1, 5))
                     uri_bytes.push_back(CH_LOWER_A + 8'($urandom_range(25)));
               end
            endcase
            if (s < segs - 1 || $urandom_range(1)) begin
               sep = $urandom_range(19);
               if (sep == 0) uri_bytes.push_back(CH_BSLASH);
               else if (sep == 1) push_escape(CH_SLASH);
               else if (sep == 2) push_escape(CH_BSLASH);
               else uri_bytes.push_back(CH_SLASH);
            end
         end
         if (kind < 30) begin
            // broken escape: cut off, or a non-hex digit in either place
            uri_bytes.push_back(CH_PERCENT);
            case ($urandom_range(3))
               0: ;
               1: uri_bytes.push_back(hex_char(4'($urandom_range(15))));
               2: uri_bytes.push_back(CH_LOWER_G + 8'($urandom_range(19)));
               default: begin
                  uri_bytes.push_back(hex_char(4'($urandom_range(15))));
                  uri_bytes.push_back(CH_UPPER_A + 8'($urandom_range(6, 25)));
               end
            endcase
         end
         if ($urandom_range(3) == 0) begin
            uri_bytes.push_back(CH_QMARK);
            repeat ($urandom_range(6)) uri_bytes.push_back(8'($urandom_range(255)));
         end
      end
   endfunction

   // Offer one byte, with random gaps before it; predict once it is taken.
   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      decode_path_byte(b, last);
   endtask

   task automatic send_uri();
      foreach (uri_bytes[i]) send_byte(uri_bytes[i], i == uri_bytes.size() - 1);
   endtask

   // Hold off the sender until every expected transaction has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write max_path_len, then read it back.
   task automatic set_path_limit(input logic [12:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_MAX_PATH_LEN;
      csr_pwdata  <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== 32'(v)) begin
         $error("max_path_len readback: expected %0d, got %0d", v, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      len_limit = v;
   endtask

   // Result side: random stalls; every taken transaction is checked in order.
   always @(posedge clock) begin
      path_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: out_byte %0h last %0b", rsp_out_byte, rsp_out_last);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_out_valid !== want.data_valid) begin
               $error("out_valid: expected %0b, got %0b", want.data_valid, rsp_out_valid);
               mismatch_count++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
               mismatch_count++;
            end
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0b, got %0b", want.accepted, rsp_accepted);
               mismatch_count++;
            end
            if (rsp_reject_reason !== want.reason) begin
               $error("reject_reason: expected %0d, got %0d", want.reason, rsp_reject_reason);
               mismatch_count++;
            end
            if (rsp_root_only !== want.root) begin
               $error("root_only: expected %0b, got %0b", want.root, rsp_root_only);
               mismatch_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   initial begin
      int unsigned sent;
      int unsigned last_idx;
      logic [12:0] phase_limit [4];
      int unsigned idle_pct [4];
      int unsigned stall_pct [4];

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= 8'd0;
      req_in_last <= 1'b0;
      rsp_ready   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_MAX_PATH_LEN;
      csr_pwdata  <= 32'd0;
      len_limit = MAX_LEN_RESET;
      clear_path_state();

      // Directed table. Rows with typed = 1 carry a verdict checked as given.
      dir_table = '{
         '{"/",            -1, 8'h00, 0,    1'b1, RSN_NONE,     1'b1},
         '{"/index.html",  -1, 8'h00, 0,    1'b1, RSN_NONE,     1'b0},
         '{"/a%2Fb%2fc",   -1, 8'h00, 0,    1'b0, RSN_NONE,     1'b0},
         '{"/a+b?q=1%zz",  -1, 8'h00, 0,    1'b0, RSN_NONE,     1'b0},
         '{"/%4",          -1, 8'h00, 0,    1'b1, RSN_BAD_ESC,  1'b0},
         '{"/%4?x",        -1, 8'h00, 0,    1'b1, RSN_BAD_ESC,  1'b0},
         '{"/%g1x",        -1, 8'h00, 0,    1'b1, RSN_BAD_ESC,  1'b0},
         '{"/%00",         -1, 8'h00, 0,    1'b1, RSN_NUL,      1'b0},
         '{"/aXb",          2, 8'h00, 0,    1'b1, RSN_NUL,      1'b0},
         '{"abc",          -1, 8'h00, 0,    1'b1, RSN_NOT_ABS,  1'b0},
         '{"?only",        -1, 8'h00, 0,    1'b1, RSN_NOT_ABS,  1'b0},
         '{"/a/../b",      -1, 8'h00, 0,    1'b1, RSN_PARENT,   1'b0},
         '{"/a/..",        -1, 8'h00, 0,    1'b1, RSN_PARENT,   1'b0},
         '{"/a\\b",        -1, 8'h00, 0,    1'b1, RSN_BSLASH,   1'b0},
         '{"/a%5c..%2fb",  -1, 8'h00, 0,    1'b1, RSN_PARENT,   1'b0},
         '{"/./.../x..",   -1, 8'h00, 0,    1'b0, RSN_NONE,     1'b0},
         '{"%2F",          -1, 8'h00, 0,    1'b0, RSN_NONE,     1'b0},
         '{"/aXz",          2, 8'hFF, 0,    1'b0, RSN_NONE,     1'b0},
         '{"/%ZZ%00",      -1, 8'h00, 0,    1'b1, RSN_BAD_ESC,  1'b0},
         '{"/%00%ZZ",      -1, 8'h00, 0,    1'b1, RSN_NUL,      1'b0},
         '{"..%2f",        -1, 8'h00, 0,    1'b1, RSN_NOT_ABS,  1'b0},
         '{"/",            -1, 8'h00, 1,    1'b1, RSN_NONE,     1'b1},
         '{"/a",           -1, 8'h00, 0,    1'b1, RSN_TOO_LONG, 1'b0},
         '{"a%",           -1, 8'h00, 0,    1'b1, RSN_TOO_LONG, 1'b0},
         '{"/%2e%2E",      -1, 8'h00, 8191, 1'b1, RSN_PARENT,   1'b0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part runs under light idling on both sides.
      send_idle_pct  = 23;
      recv_stall_pct = 23;
      foreach (dir_table[k]) begin
         if (dir_table[k].new_limit != 0) begin
            settle();
            set_path_limit(13'(dir_table[k].new_limit));
         end
         uri_bytes.delete();
         for (int i = 0; i < dir_table[k].uri.len(); i++) uri_bytes.push_back(dir_table[k].uri[i]);
         if (dir_table[k].poke_at >= 0) uri_bytes[dir_table[k].poke_at] = dir_table[k].poke_val;
         send_uri();
         // the verdict transaction was just queued and cannot have left yet
         if (dir_table[k].typed) begin
            last_idx = pending_results.size() - 1;
            pending_results[last_idx].reason   = dir_table[k].reason;
            pending_results[last_idx].accepted = (dir_table[k].reason == RSN_NONE);
            pending_results[last_idx].root     = dir_table[k].root;
         end
      end

      // Random part: four idling phases, each with its own path limit.
      idle_pct    = '{0, 65, 0, 23};
      stall_pct   = '{0, 0, 65, 23};
      phase_limit = '{13'($urandom_range(8, 48)), 13'($urandom_range(1, 12)), 13'd8191,
                      13'($urandom_range(1, 8191))};
      for (int p = 0; p < 4; p++) begin
         settle();
         set_path_limit(phase_limit[p]);
         send_idle_pct  = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         sent = 0;
         while (sent < 350) begin
            make_random_uri();
            // now and then let the block run completely dry
            if ($urandom_range(39) == 0) settle();
            send_uri();
            sent += uri_bytes.size();
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/updc_pkg.sv
rtl/updc_front.sv
rtl/updc_fifo.sv
rtl/updc_back.sv
rtl/url_path_decode_check.sv
tb/testbench.sv
